@@ design/tetu_pkg.sv @@
// Shared types and constants for the timed event table.
// No dependencies; every other file of the block but tetu_ram imports this package.
`default_nettype none
package tetu_pkg;
  localparam int TIME_W          = 32;
  localparam int TAG_W           = 16;
  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] delay;
    logic [TAG_W-1:0]  tag;
  } cmd_t;
endpackage
`default_nettype wire

@@ design/tetu_if.sv @@
// Valid/ready channel interfaces for the timed event table.
// Depends on tetu_pkg for field widths.
`default_nettype none
interface tetu_in_if;
  import tetu_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TIME_W-1:0] delay;
  logic [TAG_W-1:0]  tag;
  modport source(output valid, mode, delay, tag, input ready);
  modport sink(input valid, mode, delay, tag, output ready);
endinterface

interface tetu_out_if;
  import tetu_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [TAG_W-1:0] fired_tag;
  logic             accepted;
  logic             last;
  modport source(output valid, kind, fired_tag, accepted, last, input ready);
  modport sink(input valid, kind, fired_tag, accepted, last, output ready);
endinterface
`default_nettype wire

@@ design/timed_event_table_unit.sv @@
// Timed event table: a software-style timer list of up to TABLE_DEPTH events.
// An add puts its status result out from ST_RESP through the result register
// once the result channel has room. A tick holds the back end while the
// sequencer reads the table RAM one entry at a time through its registered
// read port and compacts survivors in the same pass; ST_FLUSH then puts out
// the last fire report. A tick on an empty table or one that fires no entry
// gives no report. A stalled result channel holds the back end longer. A
// two-entry command queue in front lets new items be taken while the back
// end is busy. Depends on tetu_pkg, tetu_if, tetu_front and tetu_back.
`default_nettype none
module timed_event_table_unit #(
  parameter int TABLE_DEPTH = tetu_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tetu_in_if.sink    item,
  tetu_out_if.source result
);
  import tetu_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tetu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tetu_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .result    (result)
  );
endmodule
`default_nettype wire

@@ design/tetu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tetu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ design/tetu_front.sv @@
// Front end: accepts input items, decodes the mode and queues commands.
// Depends on tetu_pkg and tetu_in_if.
`default_nettype none
module tetu_front (
  input  wire logic           clk,
  input  wire logic           rst,
  tetu_in_if.sink             item,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output tetu_pkg::cmd_t      cmd
);
  import tetu_pkg::*;

  cmd_t       queue [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       decoded;

  always_comb begin
    decoded.op    = item.mode ? OP_TICK : OP_ADD;
    decoded.delay = item.delay;
    decoded.tag   = item.tag;
  end

  assign item.ready = (fill != 2'd2);
  assign cmd_valid  = (fill != 2'd0);
  assign cmd        = queue[rptr];
  assign push       = item.valid && item.ready;
  assign pop        = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= decoded;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/tetu_back.sv @@
// Back end: time counter, event table sequencer and result register.
// Depends on tetu_pkg, tetu_out_if and tetu_ram.
`default_nettype none
module tetu_back #(
  parameter int TABLE_DEPTH = tetu_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire tetu_pkg::cmd_t cmd,
  tetu_out_if.source          result
);
  import tetu_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = TIME_W + TAG_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RESP  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]        state;
  logic [TIME_W-1:0] now_ticks;
  logic [CW-1:0]     count;
  logic [CW-1:0]     keep;
  logic [CW-1:0]     idx;
  logic [TAG_W-1:0]  pend_tag;
  logic              have_pend;
  logic              add_ok;

  logic              ovalid;
  logic              okind;
  logic [TAG_W-1:0]  otag;
  logic              oacc;
  logic              olast;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [EW-1:0]     rd_data;
  logic [TIME_W-1:0] rd_due;
  logic [TAG_W-1:0]  rd_tag;
  logic              fire;
  logic              last_idx;
  logic              slot_free;
  logic              eval_go;
  logic              has_room;
  logic              emit;

  tetu_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  assign result.valid     = ovalid;
  assign result.kind      = okind;
  assign result.fired_tag = otag;
  assign result.accepted  = oacc;
  assign result.last      = olast;
  assign cmd_ready        = (state == ST_IDLE);

  always_comb begin
    slot_free = !ovalid || result.ready;
    rd_due    = rd_data[EW-1:TAG_W];
    rd_tag    = rd_data[TAG_W-1:0];
    fire      = (rd_due <= now_ticks);
    last_idx  = (idx == count - CW'(1));
    eval_go   = !(fire && have_pend && !slot_free);
    has_room  = (count < DEPTH_C);
    emit      = ((state == ST_RESP) && slot_free) ||
                ((state == ST_EVAL) && eval_go && fire && have_pend) ||
                ((state == ST_FLUSH) && have_pend && slot_free);
    wr_en     = 1'b0;
    wr_addr   = count[AW-1:0];
    wr_data   = {now_ticks + cmd.delay, cmd.tag};
    if (state == ST_IDLE && cmd_valid && cmd.op == OP_ADD && has_room) begin
      wr_en = 1'b1;
    end
    if (state == ST_EVAL && eval_go && !fire) begin
      wr_en   = 1'b1;
      wr_addr = keep[AW-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_ticks <= '0;
      count     <= '0;
      have_pend <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      ovalid <= emit || (ovalid && !result.ready);
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_ADD) begin
              add_ok <= has_room;
              if (has_room) begin
                count <= count + CW'(1);
              end
              state <= ST_RESP;
            end else begin
              now_ticks <= now_ticks + TIME_W'(1);
              idx       <= '0;
              keep      <= '0;
              have_pend <= 1'b0;
              state     <= (count == '0) ? ST_IDLE : ST_READ;
            end
          end
        end
        ST_RESP: begin
          if (slot_free) begin
            okind  <= KIND_STATUS;
            otag   <= '0;
            oacc   <= add_ok;
            olast  <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (eval_go) begin
            if (fire) begin
              if (have_pend) begin
                okind  <= KIND_FIRE;
                otag   <= pend_tag;
                oacc   <= 1'b0;
                olast  <= 1'b0;
              end
              pend_tag  <= rd_tag;
              have_pend <= 1'b1;
            end else begin
              keep <= keep + CW'(1);
            end
            idx <= idx + CW'(1);
            if (last_idx) begin
              count <= fire ? keep : keep + CW'(1);
              state <= ST_FLUSH;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_FLUSH: begin
          if (!have_pend) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            okind     <= KIND_FIRE;
            otag      <= pend_tag;
            oacc      <= 1'b0;
            olast     <= 1'b1;
            have_pend <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
